/* sv/aes_pkg.sv */
package aes_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int KEY_W      = 64;
    localparam int BLOCK_W    = 128;
    localparam int IDX_W      = 1;

    localparam logic [IDX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [IDX_W-1:0] REG_KEY_LOW  = 1'b1;

    typedef logic [BLOCK_W-1:0] t_block;

    // stage-to-stage handoff
    typedef struct packed {
        logic   valid;
        t_block state;
        t_block rkey;
        logic [7:0] rcon;
    } t_stage;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
    endfunction

    // byte i of the serial order, byte 0 is the MSB
    function automatic logic [7:0] get_byte(input t_block b, input int i);
        return b[BLOCK_W-1-8*i -: 8];
    endfunction

endpackage

/* sv/aes_if.sv */
interface aes_if;
    import aes_pkg::*;
    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  data_high;
    logic [KEY_W-1:0]  data_low;
    modport source (output valid, data_high, data_low, input ready);
    modport sink   (input valid, data_high, data_low, output ready);
endinterface

/* sv/aes_cfg_if.sv */
interface aes_cfg_if;
    import aes_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [KEY_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/aes_round.sv */
module aes_round
    import aes_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_last,
    input  t_stage i_stage,
    output t_stage o_stage
);
    t_stage r_stage, n_stage;
    logic [7:0] w_sb [16];
    logic [7:0] w_mx [16];
    logic [7:0] w_t  [4];
    logic [7:0] w_nk [16];

    always_comb begin
        // SubBytes + ShiftRows
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                w_sb[4*c+r] = SBOX[get_byte(i_stage.state, 4*((c+r)%4)+r)];
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = w_sb[4*c]; a1 = w_sb[4*c+1]; a2 = w_sb[4*c+2]; a3 = w_sb[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (i_last) begin
                w_mx[4*c] = a0; w_mx[4*c+1] = a1; w_mx[4*c+2] = a2; w_mx[4*c+3] = a3;
            end else begin
                w_mx[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                w_mx[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                w_mx[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                w_mx[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        // next round key
        for (int i = 0; i < 4; i++)
            w_t[i] = SBOX[get_byte(i_stage.rkey, 12 + ((i+1)%4))];
        w_t[0] = w_t[0] ^ i_stage.rcon;
        for (int i = 0; i < 4; i++)
            w_nk[i] = get_byte(i_stage.rkey, i) ^ w_t[i];
        for (int i = 4; i < 16; i++)
            w_nk[i] = get_byte(i_stage.rkey, i) ^ w_nk[i-4];
        n_stage.valid = i_stage.valid;
        n_stage.rcon  = xtime(i_stage.rcon);
        for (int i = 0; i < 16; i++) begin
            n_stage.rkey[BLOCK_W-1-8*i -: 8]  = w_nk[i];
            n_stage.state[BLOCK_W-1-8*i -: 8] = w_mx[i] ^ w_nk[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.state <= n_stage.state;
            r_stage.rkey  <= n_stage.rkey;
            r_stage.rcon  <= n_stage.rcon;
        end
    end

    assign o_stage = r_stage;
endmodule

/* sv/aes128_block_encrypt.sv */
// Ten-cell round pipeline plus an entry register for the initial AddRoundKey.
// The path holds 11 registers: the entry register, then the ten round cells.
// Throughput: one block per cycle; the whole chain stalls while the output is held.
// Round keys travel with each block, so a new key applies to later blocks.
// Reset (i_rst_n low, synchronous) clears all valid flags and the key to zero.
module aes128_block_encrypt
    import aes_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    aes_cfg_if.sink   i_cfg,
    aes_if.sink       i_in,
    aes_if.source     o_out
);
    logic [KEY_W-1:0] r_key_high, r_key_low;
    t_stage r_head;
    t_stage w_chain [NUM_ROUNDS+1];
    logic   w_en;
    t_block w_key;

    assign w_key = {r_key_high, r_key_low};
    // advance unless the last cell holds a result not yet taken
    assign w_en  = !w_chain[NUM_ROUNDS].valid || o_out.ready;
    assign i_in.ready = w_en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_KEY_HIGH: r_key_high <= i_cfg.data;
                REG_KEY_LOW:  r_key_low  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.valid <= 1'b0;
        end else if (w_en) begin
            r_head.valid <= i_in.valid;
        end
        if (w_en) begin
            r_head.state <= {i_in.data_high, i_in.data_low} ^ w_key;
            r_head.rkey  <= w_key;
            r_head.rcon  <= 8'h01;
        end
    end

    assign w_chain[0] = r_head;

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        aes_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_last  (g == NUM_ROUNDS-1),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    assign o_out.valid     = w_chain[NUM_ROUNDS].valid;
    assign o_out.data_high = w_chain[NUM_ROUNDS].state[BLOCK_W-1:KEY_W];
    assign o_out.data_low  = w_chain[NUM_ROUNDS].state[KEY_W-1:0];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data_low))
        else $error("result changed while stalled");
    a_nostall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with empty output");
    a_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_head.valid)
        else $error("accepted block lost at entry");
endmodule

/* tb/sv/aes128_block_encrypt_checker.sv */
`timescale 1ns / 1ps
module aes128_block_encrypt_checker
    import aes_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    aes_cfg_if   cfg,
    aes_if       pt,
    aes_if       ct,
    output int   o_errors,
    output int   o_pending
);

    typedef logic [7:0] t_bytes [16];

    logic [KEY_W-1:0] key_hi, key_lo;
    t_block           cipher_q [$];

    function automatic logic [7:0] gmul2(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic t_bytes to_bytes(input t_block b);
        t_bytes r;
        for (int i = 0; i < 16; i++) begin
            r[i] = b[127-8*i -: 8];
        end
        return r;
    endfunction

    function automatic t_block encrypt(input t_block key, input t_block blk);
        t_bytes rk [11];
        t_bytes s, t;
        logic [7:0] tw [4];
        logic [7:0] rc, a0, a1, a2, a3, all;
        t_block res;
        rk[0] = to_bytes(key);
        rc = 8'h01;
        for (int r = 1; r <= NUM_ROUNDS; r++) begin
            for (int i = 0; i < 4; i++) begin
                tw[i] = SBOX[rk[r-1][12 + ((i + 1) & 3)]];
            end
            tw[0] ^= rc;
            for (int i = 0; i < 4; i++) begin
                rk[r][i] = rk[r-1][i] ^ tw[i];
            end
            for (int i = 4; i < 16; i++) begin
                rk[r][i] = rk[r-1][i] ^ rk[r][i-4];
            end
            rc = gmul2(rc);
        end
        s = to_bytes(blk);
        for (int i = 0; i < 16; i++) s[i] ^= rk[0][i];
        for (int r = 1; r <= NUM_ROUNDS; r++) begin
            for (int c = 0; c < 4; c++) begin
                for (int w = 0; w < 4; w++) begin
                    t[4*c+w] = SBOX[s[4*((c + w) & 3) + w]];
                end
            end
            s = t;
            if (r != NUM_ROUNDS) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    s[4*c]   = a0 ^ all ^ gmul2(a0 ^ a1);
                    s[4*c+1] = a1 ^ all ^ gmul2(a1 ^ a2);
                    s[4*c+2] = a2 ^ all ^ gmul2(a2 ^ a3);
                    s[4*c+3] = a3 ^ all ^ gmul2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) s[i] ^= rk[r][i];
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
        return res;
    endfunction

    assign o_pending = cipher_q.size();

    always @(posedge i_clk) begin
        t_block got, want;
        int     n_err;
        n_err = 0;
        if (!i_rst_n) begin
            key_hi   <= '0;
            key_lo   <= '0;
            o_errors <= 0;
            cipher_q.delete();
        end else begin
            if (ct.valid && ct.ready) begin
                got = {ct.data_high, ct.data_low};
                if (cipher_q.size() == 0) begin
                    $error("unexpected ciphertext %h", got);
                    n_err++;
                end else begin
                    want = cipher_q.pop_front();
                    if (got[127:64] !== want[127:64]) begin
                        $error("ciphertext_high exp %h got %h", want[127:64], got[127:64]);
                        n_err++;
                    end
                    if (got[63:0] !== want[63:0]) begin
                        $error("ciphertext_low exp %h got %h", want[63:0], got[63:0]);
                        n_err++;
                    end
                end
            end
            if (pt.valid && pt.ready) begin
                cipher_q.push_back(encrypt({key_hi, key_lo}, {pt.data_high, pt.data_low}));
            end
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_KEY_HIGH: key_hi <= cfg.data;
                    REG_KEY_LOW:  key_lo <= cfg.data;
                    default: ;
                endcase
            end
            o_errors <= o_errors + n_err;
        end
    end

endmodule

/* tb/sv/tb_aes128_block_encrypt.sv */
`timescale 1ns / 1ps
module tb_aes128_block_encrypt;
    import aes_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, cycles;
    int   send_idle_pct, recv_idle_pct;
    int   hold_off;
    logic timed_out;

    aes_cfg_if cfg ();
    aes_if     pt ();
    aes_if     ct ();

    aes128_block_encrypt dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg.sink),
        .i_in    (pt.sink),
        .o_out   (ct.source)
    );

    aes128_block_encrypt_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .cfg       (cfg),
        .pt        (pt),
        .ct        (ct),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles    = 0;
        timed_out = 1'b0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                timed_out = 1'b1;
                $display("tb_aes128_block_encrypt: errors");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        ct.ready <= 1'b0;
        hold_off = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                ct.ready <= 1'b0;
                hold_off--;
            end else begin
                ct.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic write_key(input logic [IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        while ($urandom_range(99) < send_idle_pct) begin
            pt.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt.valid     <= 1'b1;
        pt.data_high <= hi;
        pt.data_low  <= lo;
        do @(posedge i_clk); while (!pt.ready);
    endtask

    task automatic drain();
        pt.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick64();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h1;
            default: return rand64();
        endcase
    endfunction

    initial begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n      <= 1'b0;
        cfg.valid    <= 1'b0;
        cfg.index    <= REG_KEY_HIGH;
        cfg.data     <= '0;
        pt.valid     <= 1'b0;
        pt.data_high <= '0;
        pt.data_low  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset key (all zero), extremes of the block
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h8000_0000_0000_0000, 64'h1);
        send_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        drain();
        // FIPS-197 appendix key and vector
        write_key(REG_KEY_HIGH, 64'h2B7E_1516_28AE_D2A6);
        write_key(REG_KEY_LOW, 64'hABF7_1588_09CF_4F3C);
        send_block(64'h3243_F6A8_885A_308D, 64'h3131_98A2_E037_0734);
        send_block(64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF);
        drain();
        write_key(REG_KEY_HIGH, '1);
        write_key(REG_KEY_LOW, '1);
        send_block('0, '0);
        send_block('1, '1);
        drain();
        // only one half changes: new key applies to later blocks
        write_key(REG_KEY_LOW, '0);
        send_block('1, '0);
        send_block('0, '1);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 67 : 0;
            recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 26 : 0;
            for (int k = 0; k < 4; k++) begin
                write_key(REG_KEY_HIGH, pick64());
                write_key(REG_KEY_LOW, pick64());
                if (ph == 2 && k == 0) hold_off = 200;
                for (int n = 0; n < 90; n++) begin
                    send_block(pick64(), pick64());
                end
                // pause until every result is back
                drain();
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && !timed_out) begin
            $display("tb_aes128_block_encrypt: clean");
        end else begin
            $display("tb_aes128_block_encrypt: errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/aes_pkg.sv
sv/aes_if.sv
sv/aes_cfg_if.sv
sv/aes_round.sv
sv/aes128_block_encrypt.sv
tb/sv/aes128_block_encrypt_checker.sv
tb/sv/tb_aes128_block_encrypt.sv
